>>> hdl/tsh_pkg.sv
// Shared constants for the timestamped state history.
package tsh_pkg;

  // Width of a record stamp and of a query stamp
  localparam int unsigned STAMP_WIDTH = 63;

endpackage

>>> hdl/tsh_ram.sv
// Record store: one synchronous memory of (stamp, value) records with a registered read.
module tsh_ram #(
  parameter int unsigned DEPTH       = 64,
  parameter int unsigned VALUE_WIDTH = 8,
  parameter int unsigned AW          = 6
) (
  input  logic                            clk,
  input  logic                            wr_en,
  input  logic [AW-1:0]                   wr_addr,
  input  logic [tsh_pkg::STAMP_WIDTH-1:0] wr_stamp,
  input  logic [VALUE_WIDTH-1:0]          wr_value,
  input  logic                            rd_en,
  input  logic [AW-1:0]                   rd_addr,
  output logic [tsh_pkg::STAMP_WIDTH-1:0] rd_stamp,
  output logic [VALUE_WIDTH-1:0]          rd_value
);
  import tsh_pkg::*;

  localparam int unsigned RW = STAMP_WIDTH + VALUE_WIDTH;

  logic [RW-1:0] mem [DEPTH];
  logic [RW-1:0] rd_data;

  // Write a record
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_stamp, wr_value};
    end
  end

  // Register the read data
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  assign rd_stamp = rd_data[RW-1:VALUE_WIDTH];
  assign rd_value = rd_data[VALUE_WIDTH-1:0];

endmodule

>>> hdl/timestamped_state_history.sv
// Newest-first history of (value, stamp) change records with a scanning point-in-time query.
// An item is taken when start is high and busy is low; its single result appears on the
// result ports for exactly one cycle with done high, and must be captured then, since the
// receiver cannot hold it off. An update (mode 0) raises done in the cycle after it is taken,
// and busy stays low so another item can follow at once. A query (mode 1) walks the records
// newest to oldest through the record memory at one read per cycle: when k records are
// examined (1 to the record count, at most DEPTH), done rises once the last of them is read and
// checked, with busy high in between; a query on an empty history answers in the cycle after it
// is taken. The newest record is also kept in registers so an update decides without a read.
module timestamped_state_history #(
  parameter int unsigned DEPTH       = 64,
  parameter int unsigned VALUE_WIDTH = 8
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic                            mode,
  input  logic [tsh_pkg::STAMP_WIDTH-1:0] stamp,
  input  logic [VALUE_WIDTH-1:0]          entry_value,
  output logic                            done,
  output logic                            accepted,
  output logic                            found,
  output logic [VALUE_WIDTH-1:0]          result_value,
  output logic [tsh_pkg::STAMP_WIDTH-1:0] result_stamp,
  output logic                            dropped_oldest
);
  import tsh_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

  state_t                 state;
  logic [AW-1:0]          newest_slot;
  logic [CW-1:0]          record_count;
  logic [STAMP_WIDTH-1:0] newest_stamp;
  logic [VALUE_WIDTH-1:0] newest_value;
  logic [STAMP_WIDTH-1:0] query_stamp;
  logic [AW-1:0]          scan_slot;
  logic [AW-1:0]          scan_left;

  logic                   take;
  logic                   is_empty;
  logic                   is_full;
  logic                   update_ok;
  logic [AW-1:0]          insert_slot;
  logic [AW-1:0]          older_slot;
  logic [CW-1:0]          count_less;
  logic                   hit;
  logic                   scan_end;
  logic                   rd_en;
  logic [AW-1:0]          rd_addr;
  logic                   wr_en;
  logic [STAMP_WIDTH-1:0] rd_stamp;
  logic [VALUE_WIDTH-1:0] rd_value;

  // Decode the incoming item against the cached newest record
  assign take        = start && !busy;
  assign is_empty    = (record_count == '0);
  assign is_full     = (record_count == FULL_COUNT);
  assign update_ok   = is_empty || ((stamp > newest_stamp) && (entry_value != newest_value));
  assign insert_slot = is_empty ? '0 :
                       ((newest_slot == LAST_SLOT) ? '0 : newest_slot + AW'(1));
  assign count_less  = record_count - CW'(1);

  // Step the scan to the next older slot, wrapping at the bottom
  assign older_slot  = (scan_slot == '0) ? LAST_SLOT : scan_slot - AW'(1);
  assign hit         = (query_stamp >= rd_stamp);
  assign scan_end    = hit || (scan_left == '0);

  // Drive the record memory ports
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = newest_slot;
    case (state)
      ST_IDLE: begin
        rd_en   = take && mode && !is_empty;
        rd_addr = newest_slot;
      end
      ST_SCAN: begin
        rd_en   = !scan_end;
        rd_addr = older_slot;
      end
      default: begin
        rd_en   = 1'b0;
        rd_addr = newest_slot;
      end
    endcase
  end

  assign wr_en = (state == ST_IDLE) && take && !mode && update_ok;
  assign busy  = (state != ST_IDLE);

  tsh_ram #(
    .DEPTH       (DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH),
    .AW          (AW)
  ) u_ram (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_addr  (insert_slot),
    .wr_stamp (stamp),
    .wr_value (entry_value),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_stamp (rd_stamp),
    .rd_value (rd_value)
  );

  // Hold state, history pointers and the registered result
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      done         <= 1'b0;
      newest_slot  <= '0;
      record_count <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (take) begin
            if (!mode) begin
              // Insert in front, or reject
              done           <= 1'b1;
              accepted       <= update_ok;
              found          <= 1'b0;
              result_value   <= '0;
              result_stamp   <= '0;
              dropped_oldest <= update_ok && is_full;
              if (update_ok) begin
                newest_slot  <= insert_slot;
                newest_stamp <= stamp;
                newest_value <= entry_value;
                if (!is_full) begin
                  record_count <= record_count + CW'(1);
                end
              end
            end else if (is_empty) begin
              // Answer not found at once
              done           <= 1'b1;
              accepted       <= 1'b0;
              found          <= 1'b0;
              result_value   <= '0;
              result_stamp   <= '0;
              dropped_oldest <= 1'b0;
            end else begin
              // Start the walk at the newest record
              query_stamp <= stamp;
              scan_slot   <= newest_slot;
              scan_left   <= count_less[AW-1:0];
              state       <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (scan_end) begin
            // First record at or before the stamp, or the oldest one
            done           <= 1'b1;
            accepted       <= 1'b0;
            found          <= 1'b1;
            result_value   <= rd_value;
            result_stamp   <= query_stamp;
            dropped_oldest <= 1'b0;
            state          <= ST_IDLE;
          end else begin
            scan_slot <= older_slot;
            scan_left <= scan_left - AW'(1);
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
